>>> rtl/sfp_pkg.sv
// sfp_pkg: shared types and constants of the sample frame player
// configuration record, multiplier request, register indexes and item kinds
// no dependencies
package sfp_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int LEN_W = 7;
	localparam int NUM_W = 13;
	localparam int GAIN_W = 16;
	localparam int POS_W = 16;
	localparam int SMP_W = 16;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 17;
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SAMPLES   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_RATIO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VOLUME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd5;

	// item kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// register values after reset
	localparam logic [LEN_W-1:0]  RST_FRAME_LENGTH  = 7'd64;
	localparam logic [NUM_W-1:0]  RST_NUM_SAMPLES   = 13'd0;
	localparam logic [GAIN_W-1:0] RST_PITCH_RATIO   = 16'd256;
	localparam logic [GAIN_W-1:0] RST_SOURCE_VOLUME = 16'd32768;
	localparam logic [GAIN_W-1:0] RST_MASTER_GAIN   = 16'd32768;

	typedef struct packed {
		logic [LEN_W-1:0]  frame_length;
		logic [NUM_W-1:0]  num_samples;
		logic [GAIN_W-1:0] pitch_ratio;
		logic [GAIN_W-1:0] source_volume;
		logic [GAIN_W-1:0] master_gain;
		logic              loop_enable;
	} cfg_t;

	// one request to the shared multiplier, operands as two's complement
	typedef struct packed {
		logic               en;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

>>> rtl/sfp_in_if.sv
// sfp_in_if: input channel of the sample frame player
// valid/ready handshake with the item fields; no dependencies
interface sfp_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [11:0]        sample_addr;
	logic signed [15:0] sample_value;
	logic [11:0]        start_frame;

	modport source (output valid, kind, sample_addr, sample_value, start_frame, input ready);
	modport sink (input valid, kind, sample_addr, sample_value, start_frame, output ready);
endinterface

>>> rtl/sfp_out_if.sv
// sfp_out_if: result channel of the sample frame player
// valid/ready handshake with the result fields; no dependencies
interface sfp_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               last;
	logic               reached_end;

	modport source (output valid, sample_out, last, reached_end, input ready);
	modport sink (input valid, sample_out, last, reached_end, output ready);
endinterface

>>> rtl/sample_frame_player.sv
// sample_frame_player: top level, sample store playback with pitch, loop and gain
// depends on sfp_pkg, sfp_in_if, sfp_out_if, sfp_cfg, sfp_mul, sfp_seq
//
// channel   direction  handshake      carries
// din       in         valid/ready    kind, sample_addr, sample_value, start_frame
// dout      out        valid/ready    sample_out, last, reached_end
// wr_*      in         write enable   register index and data, no read-back
//
// a read frame computes the frame base once and then, for every sample, the index
// and both gain steps on the single shared multiplier; a wrap restarts the index
// step, and the samples after the one that runs past the end of the buffer are
// emitted as zeros from the emit step alone.
// din is ready only while the sequencer is idle; a stalled dout holds the
// sequencer in its emit step. arst_n clears control state and the registers;
// the sample store has no reset.
module sample_frame_player #(
	parameter int SAMPLE_DEPTH = 4096,
	parameter int MAX_FRAME_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sfp_in_if.sink                        din,
	sfp_out_if.source                     dout,
	input  logic                          wr_en,
	input  logic [sfp_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [sfp_pkg::CFG_DATA_W-1:0] wr_data
);
	import sfp_pkg::*;

	cfg_t              cfg;
	mul_req_t          mul_req;
	logic [PROD_W-1:0] prod;

	// configuration registers
	sfp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// shared multiplier
	sfp_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	// sequencer with store and output register
	sfp_seq #(
		.SAMPLE_DEPTH  (SAMPLE_DEPTH),
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.din     (din),
		.dout    (dout),
		.mul_req (mul_req),
		.prod    (prod)
	);

endmodule

>>> rtl/sfp_cfg.sv
// sfp_cfg: configuration register file of the sample frame player
// depends on sfp_pkg
module sfp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [sfp_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [sfp_pkg::CFG_DATA_W-1:0] wr_data,
	output sfp_pkg::cfg_t                 cfg
);
	import sfp_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_length  <= RST_FRAME_LENGTH;
			cfg_q.num_samples   <= RST_NUM_SAMPLES;
			cfg_q.pitch_ratio   <= RST_PITCH_RATIO;
			cfg_q.source_volume <= RST_SOURCE_VOLUME;
			cfg_q.master_gain   <= RST_MASTER_GAIN;
			cfg_q.loop_enable   <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME_LENGTH:  cfg_q.frame_length  <= wr_data[LEN_W-1:0];
				REG_NUM_SAMPLES:   cfg_q.num_samples   <= wr_data[NUM_W-1:0];
				REG_PITCH_RATIO:   cfg_q.pitch_ratio   <= wr_data;
				REG_SOURCE_VOLUME: cfg_q.source_volume <= wr_data;
				REG_MASTER_GAIN:   cfg_q.master_gain   <= wr_data;
				REG_LOOP_ENABLE:   cfg_q.loop_enable   <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/sfp_mul.sv
// sfp_mul: shared signed multiplier with a registered product
// used for frame base, source index and both gain steps; depends on sfp_pkg
module sfp_mul (
	input  logic                       clk,
	input  sfp_pkg::mul_req_t          req,
	output logic [sfp_pkg::PROD_W-1:0] prod
);
	import sfp_pkg::*;

	logic [PROD_W-1:0] prod_q;

	// product held until the next request
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'($signed(req.a) * $signed(req.b));
		end
	end

	assign prod = prod_q;

endmodule

>>> rtl/sfp_seq.sv
// sfp_seq: sequencer, sample store and output register of the frame player
// drives the shared multiplier; depends on sfp_pkg, sfp_in_if, sfp_out_if
module sfp_seq #(
	parameter int SAMPLE_DEPTH = 4096,
	parameter int MAX_FRAME_LEN = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sfp_pkg::cfg_t              cfg,
	sfp_in_if.sink                     din,
	sfp_out_if.source                  dout,
	output sfp_pkg::mul_req_t          mul_req,
	input  logic [sfp_pkg::PROD_W-1:0] prod
);
	import sfp_pkg::*;

	localparam int AW = $clog2(SAMPLE_DEPTH);
	localparam int BASE_W = 23;
	localparam int IDX_W = 31;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_LEN);
	localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << 29;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_BASE  = 8'b0000_0010,
		S_BASEW = 8'b0000_0100,
		S_IDX   = 8'b0000_1000,
		S_CMP   = 8'b0001_0000,
		S_VOL   = 8'b0010_0000,
		S_GAIN  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   done_q;
	logic [LEN_W-1:0]   k_q;
	logic [POS_W-1:0]   pos_q;
	logic [BASE_W-1:0]  base_q;
	logic               ended_q;
	logic               out_valid_q;
	logic [SMP_W-1:0]   sample_q;
	logic               last_q;
	logic               end_q;
	logic [SMP_W-1:0]   store_mem [SAMPLE_DEPTH];
	logic [SMP_W-1:0]   rd_q;

	logic               accept;
	logic [LEN_W-1:0]   len_in;
	logic [IDX_W-1:0]   idx;
	logic               beyond;
	logic               loop_hit;
	logic               can_load;
	logic               out_load;
	logic               last_now;
	logic [PROD_W-1:0]  rnd;
	logic signed [19:0] scaled;
	logic [SMP_W-1:0]   sat;

	assign accept = din.valid && (state_q == S_IDLE);
	assign din.ready = (state_q == S_IDLE);

	// frame length clamped to 1..MAX_FRAME_LEN
	always_comb begin
		if (cfg.frame_length == '0) begin
			len_in = LEN_W'(1);
		end else if (cfg.frame_length > MAX_LEN) begin
			len_in = MAX_LEN;
		end else begin
			len_in = cfg.frame_length;
		end
	end

	// source index and end of buffer test
	assign idx = prod[8 +: IDX_W];
	assign beyond = idx >= IDX_W'(cfg.num_samples);
	assign loop_hit = beyond && cfg.loop_enable && (cfg.num_samples != '0);

	// round to nearest and saturate the gain product
	assign rnd = prod + ROUND_BIAS;
	assign scaled = $signed(rnd[PROD_W-1:30]);
	always_comb begin
		if (scaled > 20'sd32767) begin
			sat = 16'h7fff;
		end else if (scaled < -20'sd32768) begin
			sat = 16'h8000;
		end else begin
			sat = scaled[SMP_W-1:0];
		end
	end

	assign can_load = !out_valid_q || dout.ready;
	assign out_load = (state_q == S_EMIT) && can_load;
	assign last_now = (done_q == len_q - LEN_W'(1));

	// operand selection for the shared multiplier
	always_comb begin
		mul_req = '0;
		unique case (state_q)
			S_BASE: begin
				mul_req.en = 1'b1;
				mul_req.a = MUL_A_W'(len_q);
				mul_req.b = MUL_B_W'(pos_q);
			end
			S_IDX: begin
				mul_req.en = 1'b1;
				mul_req.a = MUL_A_W'({1'b0, base_q} + (BASE_W + 1)'(k_q));
				mul_req.b = MUL_B_W'(cfg.pitch_ratio);
			end
			S_VOL: begin
				mul_req.en = 1'b1;
				mul_req.a = {{(MUL_A_W - SMP_W){rd_q[SMP_W-1]}}, rd_q};
				mul_req.b = MUL_B_W'(cfg.source_volume);
			end
			S_GAIN: begin
				mul_req.en = 1'b1;
				mul_req.a = prod[MUL_A_W-1:0];
				mul_req.b = MUL_B_W'(cfg.master_gain);
			end
			default: ;
		endcase
	end

	// sample store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (accept && din.kind == KIND_LOAD) begin
			store_mem[AW'(din.sample_addr)] <= din.sample_value;
		end
		rd_q <= store_mem[AW'(idx)];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			done_q  <= '0;
			k_q     <= '0;
			pos_q   <= '0;
			base_q  <= '0;
			ended_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (din.kind)
							KIND_START: pos_q <= POS_W'(din.start_frame);
							KIND_READ: begin
								len_q   <= len_in;
								done_q  <= '0;
								k_q     <= '0;
								ended_q <= 1'b0;
								state_q <= S_BASE;
							end
							default: ;
						endcase
					end
				end
				S_BASE:  state_q <= S_BASEW;
				S_BASEW: begin
					base_q  <= prod[BASE_W-1:0];
					state_q <= S_IDX;
				end
				S_IDX: state_q <= S_CMP;
				S_CMP: begin
					if (loop_hit) begin
						pos_q   <= '0;
						base_q  <= '0;
						k_q     <= '0;
						state_q <= S_IDX;
					end else if (beyond) begin
						ended_q <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_VOL;
					end
				end
				S_VOL:  state_q <= S_GAIN;
				S_GAIN: state_q <= S_EMIT;
				S_EMIT: begin
					if (can_load) begin
						done_q <= done_q + LEN_W'(1);
						k_q    <= k_q + LEN_W'(1);
						if (last_now) begin
							if (!ended_q && pos_q != '1) begin
								pos_q <= pos_q + POS_W'(1);
							end
							state_q <= S_IDLE;
						end else if (!ended_q) begin
							state_q <= S_IDX;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_q <= ended_q ? '0 : sat;
			last_q   <= last_now;
			end_q    <= ended_q;
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.sample_out  = sample_q;
	assign dout.last        = last_q;
	assign dout.reached_end = end_q;

	// frame count stays inside the frame while busy
	a_done_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> done_q < len_q)
		else $error("frame count beyond frame length");

	// the index offset never runs ahead of the emitted count
	a_k_le_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> k_q <= done_q)
		else $error("index offset ahead of emitted count");

	// a wrap restarts from the first frame
	a_loop_restart: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP && loop_hit |=> k_q == '0 && pos_q == '0 && state_q == S_IDX)
		else $error("wrap did not restart at the first frame");

	// once the end is hit it stays flagged for the rest of the frame
	a_end_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q && state_q != S_IDLE |=> ended_q)
		else $error("end flag dropped inside a frame");

	// the last result of a frame returns the sequencer to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && last_now |=> state_q == S_IDLE && dout.valid && dout.last)
		else $error("last result did not close the frame");

endmodule

>>> tb/sample_frame_player_test.sv
`timescale 1ns / 1ps
// sample_frame_player_test: self-checking bench for the sample frame player
// drives load, start and read transactions, predicts every output sample and checks it
// depends on sfp_pkg, sfp_in_if, sfp_out_if and sample_frame_player
module sample_frame_player_test;
	import sfp_pkg::*;

	localparam int STORE_DEPTH = 4096;
	localparam int FRAME_MAX = 64;
	localparam int CLK_HALF_NS = 4;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int GAP_PERCENT = 32;
	localparam int PRINT_CAP = 100;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam longint ROUND_HALF = 64'sd536870912;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               last;
		logic               reached_end;
	} out_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	sfp_in_if  din_bus ();
	sfp_out_if dout_bus ();

	sample_frame_player #(
		.SAMPLE_DEPTH(STORE_DEPTH),
		.MAX_FRAME_LEN(FRAME_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_bus),
		.dout(dout_bus),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// shadow copy of the player state
	logic [15:0]      store_mirror [STORE_DEPTH];
	bit               store_loaded [STORE_DEPTH];
	logic [POS_W-1:0] play_position;
	cfg_t             regs_now;
	out_beat_t        expected_beats [$];
	int unsigned      unloaded_idx [$];
	out_beat_t        oldest_beat;
	bit               gaps_on;
	int unsigned      mismatch_count;
	int unsigned      results_seen;
	int unsigned      cycle_count;
	int unsigned      items_sent;

	// clock
	initial clk = 1'b0;
	always #(CLK_HALF_NS) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic cfg_t make_cfg(input int unsigned len, input int unsigned num,
			input int unsigned pitch, input int unsigned vol, input int unsigned gain,
			input bit loop_on);
		cfg_t c;
		c.frame_length = len[LEN_W-1:0];
		c.num_samples = num[NUM_W-1:0];
		c.pitch_ratio = pitch[GAIN_W-1:0];
		c.source_volume = vol[GAIN_W-1:0];
		c.master_gain = gain[GAIN_W-1:0];
		c.loop_enable = loop_on;
		return c;
	endfunction

	// q1.15 volume times q1.15 gain, round half up, saturate to 16 bits
	function automatic logic [15:0] apply_gain(input logic [15:0] raw);
		longint prod;
		longint scaled;
		prod = longint'($signed(raw)) * longint'(regs_now.source_volume)
			* longint'(regs_now.master_gain);
		scaled = (prod + ROUND_HALF) >>> 30;
		if (scaled > 32767)
			scaled = 32767;
		else if (scaled < -32768)
			scaled = -32768;
		return scaled[15:0];
	endfunction

	// walk one frame; commit pushes the expected samples and moves the position,
	// otherwise only the store entries not yet loaded are collected
	function automatic void walk_frame(input bit commit);
		longint unsigned len;
		longint unsigned pos;
		longint unsigned k;
		longint unsigned idx;
		int unsigned     done;
		int unsigned     slot;
		bit              ended;
		out_beat_t       beat;
		len = 64'(regs_now.frame_length);
		if (len < 1)
			len = 1;
		if (len > FRAME_MAX)
			len = FRAME_MAX;
		pos = 64'(play_position);
		k = 0;
		done = 0;
		ended = 1'b0;
		while (done < len) begin
			idx = ((len * pos + k) * regs_now.pitch_ratio) >> 8;
			slot = 32'(idx % STORE_DEPTH);
			if (idx >= regs_now.num_samples && regs_now.loop_enable
					&& regs_now.num_samples != 0) begin
				// wrap to the first frame and start the frame over
				pos = 0;
				k = 0;
			end else begin
				if (idx >= regs_now.num_samples)
					ended = 1'b1;
				else if (!commit && !store_loaded[slot])
					unloaded_idx.push_back(slot);
				if (commit) begin
					beat.sample_out = ended ? 16'sd0 : apply_gain(store_mirror[slot]);
					beat.last = (done == len - 1);
					beat.reached_end = ended;
					expected_beats.push_back(beat);
				end
				done++;
				k++;
			end
		end
		if (commit) begin
			play_position = pos[POS_W-1:0];
			if (!ended && play_position != {POS_W{1'b1}})
				play_position++;
		end
	endfunction

	// update the shadow state for one accepted transaction
	function automatic void record_item(input logic [1:0] kind, input logic [11:0] addr,
			input logic [15:0] value, input logic [11:0] frame);
		case (kind)
			KIND_LOAD: begin
				store_mirror[addr] = value;
				store_loaded[addr] = 1'b1;
			end
			KIND_START: play_position = POS_W'(frame);
			KIND_READ: walk_frame(1'b1);
			// unused kind is ignored
			default: ;
		endcase
	endfunction

	function automatic logic [15:0] random_sample();
		case ($urandom_range(7, 0))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int unsigned random_gain();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 40)
			return 32768;
		else if (roll < 80)
			return $urandom_range(65535, 0);
		else if (roll < 90)
			return 0;
		return 65535;
	endfunction

	task automatic report(input string what, input int got, input int want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t, result %0d: %s got %0d expected %0d",
				$time, results_seen, what, got, want);
		mismatch_count++;
	endtask

	// send one transaction, with random idle cycles ahead of it while gaps are on
	task automatic send_item(input logic [1:0] kind, input logic [11:0] addr,
			input logic [15:0] value, input logic [11:0] frame);
		while (gaps_on && $urandom_range(99, 0) < GAP_PERCENT) begin
			din_bus.valid <= 1'b0;
			@(posedge clk);
		end
		din_bus.valid <= 1'b1;
		din_bus.kind <= kind;
		din_bus.sample_addr <= addr;
		din_bus.sample_value <= value;
		din_bus.start_frame <= frame;
		@(posedge clk);
		while (!din_bus.ready)
			@(posedge clk);
		record_item(kind, addr, value, frame);
		items_sent++;
	endtask

	// read a frame, loading first any store entry it would touch unwritten
	task automatic read_frame();
		int unsigned slot;
		unloaded_idx.delete();
		walk_frame(1'b0);
		while (unloaded_idx.size() != 0) begin
			slot = unloaded_idx.pop_front();
			if (!store_loaded[slot])
				send_item(KIND_LOAD, slot[11:0], random_sample(), 12'($urandom));
		end
		send_item(KIND_READ, 12'($urandom), 16'($urandom), 12'($urandom));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= index;
		wr_data <= data;
		@(posedge clk);
	endtask

	// wait for the player to go idle, then write every register
	task automatic reconfigure(input cfg_t target);
		din_bus.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_FRAME_LENGTH, CFG_DATA_W'(target.frame_length));
		write_reg(REG_NUM_SAMPLES, CFG_DATA_W'(target.num_samples));
		write_reg(REG_PITCH_RATIO, target.pitch_ratio);
		write_reg(REG_SOURCE_VOLUME, target.source_volume);
		write_reg(REG_MASTER_GAIN, target.master_gain);
		write_reg(REG_LOOP_ENABLE, CFG_DATA_W'(target.loop_enable));
		wr_en <= 1'b0;
		regs_now = target;
		@(posedge clk);
	endtask

	// after reset the store is empty: every sample is zero and flags the end
	task automatic test_empty_buffer();
		read_frame();
		send_item(KIND_START, '0, '0, 12'hFFF);
		read_frame();
	endtask

	// unity, half, full and zero gain over the sample extremes
	task automatic test_gain_and_rounding();
		reconfigure(make_cfg(6, 6, 256, 32768, 32768, 0));
		send_item(KIND_LOAD, 12'd0, 16'h7FFF, '0);
		send_item(KIND_LOAD, 12'd1, 16'h8000, '0);
		send_item(KIND_LOAD, 12'd2, 16'h0001, '0);
		send_item(KIND_LOAD, 12'd3, 16'hFFFF, '0);
		send_item(KIND_LOAD, 12'd4, 16'h0000, '0);
		send_item(KIND_LOAD, 12'hFFF, 16'h5A5A, 12'hFFF);
		send_item(KIND_START, '0, '0, '0);
		read_frame();
		// half gain lands exactly on the rounding ties
		reconfigure(make_cfg(6, 6, 256, 16384, 32768, 0));
		send_item(KIND_START, '0, '0, '0);
		read_frame();
		reconfigure(make_cfg(6, 6, 256, 65535, 65535, 0));
		send_item(KIND_START, '0, '0, '0);
		read_frame();
		reconfigure(make_cfg(6, 6, 256, 0, 65535, 0));
		send_item(KIND_START, '0, '0, '0);
		read_frame();
	endtask

	// zero length acts as one, lengths over the maximum are clipped
	task automatic test_frame_length_limits();
		reconfigure(make_cfg(0, 6, 256, 32768, 32768, 0));
		send_item(KIND_START, '0, '0, '0);
		read_frame();
		reconfigure(make_cfg(127, 6, 256, 32768, 32768, 0));
		send_item(KIND_START, '0, '0, '0);
		read_frame();
	endtask

	task automatic test_loop_and_end();
		// past the end without looping: zeros flagged, position holds
		reconfigure(make_cfg(4, 6, 256, 32768, 32768, 0));
		send_item(KIND_START, '0, '0, 12'd1);
		read_frame();
		read_frame();
		// with looping the frame carries on from the first sample
		reconfigure(make_cfg(4, 6, 256, 32768, 32768, 1));
		send_item(KIND_START, '0, '0, 12'd1);
		read_frame();
		read_frame();
		// an empty buffer never loops
		reconfigure(make_cfg(4, 0, 256, 32768, 32768, 1));
		read_frame();
	endtask

	task automatic test_pitch_extremes();
		reconfigure(make_cfg(4, 6, 0, 32768, 32768, 0));
		send_item(KIND_START, '0, '0, 12'hFFF);
		read_frame();
		read_frame();
		reconfigure(make_cfg(4, 4096, 65535, 32768, 32768, 0));
		send_item(KIND_START, '0, '0, '0);
		read_frame();
		send_item(KIND_START, '0, '0, 12'd15);
		read_frame();
	endtask

	// sample counts above the store depth wrap the read index
	task automatic test_store_wrap();
		reconfigure(make_cfg(4, 8191, 256, 32768, 32768, 0));
		send_item(KIND_START, '0, '0, 12'd1100);
		read_frame();
		send_item(KIND_START, '0, '0, 12'd2047);
		read_frame();
	endtask

	task automatic test_unused_kind();
		send_item(KIND_UNUSED, 12'hFFF, 16'hFFFF, 12'hFFF);
		send_item(KIND_UNUSED, '0, '0, '0);
		read_frame();
	endtask

	// random settings, mostly start-then-read sequences near the buffer end
	task automatic test_random_traffic(input int unsigned item_goal);
		int unsigned first;
		int unsigned roll;
		int unsigned len;
		int unsigned num;
		int unsigned pitch;
		int unsigned len_eff;
		int unsigned span;
		int unsigned hi;
		int unsigned lo;
		int unsigned reads;
		first = items_sent;
		while (items_sent - first < item_goal) begin
			roll = $urandom_range(99, 0);
			if (roll < 70)
				len = $urandom_range(8, 1);
			else if (roll < 90)
				len = $urandom_range(64, 9);
			else if (roll < 95)
				len = $urandom_range(127, 65);
			else
				len = 0;
			roll = $urandom_range(99, 0);
			if (roll < 10)
				num = 0;
			else if (roll < 65)
				num = $urandom_range(64, 1);
			else if (roll < 90)
				num = $urandom_range(4096, 65);
			else
				num = $urandom_range(8191, 4097);
			roll = $urandom_range(99, 0);
			if (roll < 50)
				pitch = $urandom_range(512, 128);
			else if (roll < 65)
				pitch = $urandom_range(127, 0);
			else if (roll < 85)
				pitch = $urandom_range(4096, 513);
			else
				pitch = $urandom_range(65535, 0);
			reconfigure(make_cfg(len, num, pitch, random_gain(), random_gain(),
				1'($urandom_range(1, 0))));
			len_eff = (len == 0) ? 1 : (len > FRAME_MAX) ? FRAME_MAX : len;
			span = (pitch == 0) ? 4095 : (num * 256) / (pitch * len_eff);
			hi = (span + 1 > 4095) ? 4095 : span + 1;
			lo = (hi > 3) ? hi - 3 : 0;
			repeat ($urandom_range(10, 4)) begin
				if (items_sent - first >= item_goal)
					break;
				roll = $urandom_range(99, 0);
				if (roll < 55) begin
					// start close to the end of the buffer, then play on
					if ($urandom_range(2, 0) != 0)
						send_item(KIND_START, 12'($urandom), 16'($urandom),
							12'($urandom_range(hi, lo)));
					else
						send_item(KIND_START, 12'($urandom), 16'($urandom),
							12'($urandom_range(hi, 0)));
					reads = $urandom_range(3, 1);
					repeat (reads) read_frame();
				end else if (roll < 70) begin
					read_frame();
				end else if (roll < 82) begin
					send_item(KIND_LOAD, 12'($urandom), random_sample(), 12'($urandom));
				end else if (roll < 88) begin
					send_item(KIND_UNUSED, 12'($urandom), 16'($urandom), 12'($urandom));
				end else begin
					send_item(KIND_START, 12'($urandom), 16'($urandom), 12'($urandom));
				end
			end
		end
	endtask

	// receiver stalls
	initial begin
		dout_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			dout_bus.ready <= gaps_on ? ($urandom_range(99, 0) >= GAP_PERCENT) : 1'b1;
		end
	end

	// compare every result transaction with the oldest expected sample
	always @(posedge clk) begin
		if (arst_n && dout_bus.valid && dout_bus.ready) begin
			results_seen <= results_seen + 1;
			if (expected_beats.size() == 0) begin
				report("unexpected result, sample_out", dout_bus.sample_out, 0);
			end else begin
				oldest_beat = expected_beats.pop_front();
				if (dout_bus.sample_out !== oldest_beat.sample_out)
					report("sample_out", dout_bus.sample_out, oldest_beat.sample_out);
				if (dout_bus.last !== oldest_beat.last)
					report("last", dout_bus.last, oldest_beat.last);
				if (dout_bus.reached_end !== oldest_beat.reached_end)
					report("reached_end", dout_bus.reached_end, oldest_beat.reached_end);
			end
		end
	end

	// test sequence
	initial begin
		gaps_on = 1'b1;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		din_bus.valid <= 1'b0;
		din_bus.kind <= KIND_LOAD;
		din_bus.sample_addr <= '0;
		din_bus.sample_value <= '0;
		din_bus.start_frame <= '0;
		regs_now = make_cfg(32'(RST_FRAME_LENGTH), 32'(RST_NUM_SAMPLES),
			32'(RST_PITCH_RATIO), 32'(RST_SOURCE_VOLUME), 32'(RST_MASTER_GAIN), 1'b0);
		play_position = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_buffer();
		test_gain_and_rounding();
		test_frame_length_limits();
		test_loop_and_end();
		test_pitch_extremes();
		test_store_wrap();
		test_unused_kind();
		test_random_traffic(40);
		gaps_on = 1'b0;
		test_random_traffic(20);

		din_bus.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_beats.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
rtl/sfp_pkg.sv
rtl/sfp_in_if.sv
rtl/sfp_out_if.sv
rtl/sfp_cfg.sv
rtl/sfp_mul.sv
rtl/sfp_seq.sv
rtl/sample_frame_player.sv
tb/sample_frame_player_test.sv
